### hw/rtl/skt_pkg.sv
package skt_pkg;

   // operation codes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_COUNT  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // request item
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] key;
   } skt_req_type;

   // result item
   typedef struct packed {
      logic [1:0] status;
      logic [4:0] position;
      logic [4:0] entries_held;
   } skt_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       capture;
      logic       count_clr;
      logic       scan;
      logic       sh_init_up;
      logic       sh_init_dn;
      logic       shift_up;
      logic       shift_dn;
      logic       count_inc;
      logic       count_dec;
      logic       load_rsp;
      logic       pos_zero;
      logic [1:0] status;
   } skt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic full;
      logic up_last;
      logic dn_last;
   } skt_stat_type;

endpackage

### hw/rtl/skt_datapath.sv
module skt_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [31:0]   req_key,
   input  skt_pkg::skt_cmd_type cmd,
   output skt_pkg::skt_stat_type stat,
   output skt_pkg::skt_rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int OW = (CW > 5) ? CW : 5;

   // key memory, ascending in slots below the fill count
   logic [31:0] mem [DEPTH];

   logic signed [31:0] key_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      walk_ff;
   logic [CW-1:0]      sh_ff;
   logic [CW-1:0]      pos_ff;
   logic               hit_ff;
   logic signed [31:0] rd_data_ff;
   logic [CW-1:0]      rd_idx_ff;
   logic               rd_vld_ff;
   logic               wr_vld_ff;
   logic [CW-1:0]      wr_idx_ff;
   logic               wr_key_ff;
   skt_pkg::skt_rsp_type rsp_ff;

   logic [CW-1:0] rd_addr_in;
   logic [CW-1:0] sh_dec;
   logic [CW-1:0] sh_inc;
   logic          at_end;
   logic          not_less;
   logic [OW-1:0] pos_ext;
   logic [OW-1:0] cnt_ext;

   assign sh_dec   = sh_ff - CW'(1);
   assign sh_inc   = sh_ff + CW'(1);
   assign at_end   = (rd_idx_ff == count_ff);
   assign not_less = !(rd_data_ff < key_ff);

   assign stat.scan_done = rd_vld_ff && (at_end || not_less);
   assign stat.hit       = hit_ff;
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.up_last   = (sh_ff == pos_ff);
   assign stat.dn_last   = !(sh_inc < count_ff);

   // read address select
   always_comb begin
      if (cmd.shift_up) begin
         rd_addr_in = sh_dec;
      end else if (cmd.shift_dn) begin
         rd_addr_in = sh_inc;
      end else begin
         rd_addr_in = walk_ff;
      end
   end

   // memory port: one registered read, one write from the shift pipeline
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr_in[AW-1:0]];
      if (wr_vld_ff) begin
         mem[wr_idx_ff[AW-1:0]] <= wr_key_ff ? key_ff : rd_data_ff;
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_clr) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // pending write stage
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan;
         wr_vld_ff <= (cmd.shift_up) || (cmd.shift_dn && (sh_inc < count_ff));
      end
   end

   // walk, shift index and search result
   always_ff @(posedge clock) begin
      rd_idx_ff <= walk_ff;
      if (cmd.capture) begin
         key_ff  <= req_key;
         walk_ff <= '0;
      end else if (cmd.scan) begin
         walk_ff <= walk_ff + CW'(1);
      end
      if (cmd.scan && stat.scan_done) begin
         pos_ff <= rd_idx_ff;
         hit_ff <= !at_end && (rd_data_ff == key_ff);
      end
      if (cmd.sh_init_up) begin
         sh_ff <= count_ff;
      end else if (cmd.sh_init_dn) begin
         sh_ff <= pos_ff;
      end else if (cmd.shift_up && !stat.up_last) begin
         sh_ff <= sh_dec;
      end else if (cmd.shift_dn) begin
         sh_ff <= sh_inc;
      end
      if (cmd.shift_up) begin
         wr_idx_ff <= sh_ff;
         wr_key_ff <= stat.up_last;
      end else begin
         wr_idx_ff <= sh_ff;
         wr_key_ff <= 1'b0;
      end
   end

   // result register
   assign pos_ext = OW'(pos_ff);
   assign cnt_ext = OW'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status       <= cmd.status;
         rsp_ff.position     <= cmd.pos_zero ? 5'd0 : pos_ext[4:0];
         rsp_ff.entries_held <= cnt_ext[4:0];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### hw/rtl/skt_ctrl.sv
module skt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_op,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  skt_pkg::skt_stat_type stat,
   output skt_pkg::skt_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DECIDE,
      SHIFT_UP,
      SHIFT_DN,
      DRAIN,
      RESP
   } state_type;

   state_type  state_ff;
   logic [2:0] op_ff;
   logic [1:0] st_ff;
   logic       pz_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       rsp_free;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && (state_ff == IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.status     = st_ff;
      cmd.pos_zero   = pz_ff;
      cmd.capture    = accept;
      cmd.count_clr  = accept && (req_op == skt_pkg::OP_CLEAR);
      cmd.scan       = (state_ff == SCAN);
      cmd.shift_up   = (state_ff == SHIFT_UP);
      cmd.shift_dn   = (state_ff == SHIFT_DN);
      cmd.sh_init_up = (state_ff == DECIDE) && (op_ff == skt_pkg::OP_INSERT)
                       && !stat.hit && !stat.full;
      cmd.sh_init_dn = (state_ff == DECIDE) && (op_ff == skt_pkg::OP_DELETE) && stat.hit;
      cmd.count_inc  = (state_ff == DRAIN) && (op_ff == skt_pkg::OP_INSERT);
      cmd.count_dec  = (state_ff == DRAIN) && (op_ff == skt_pkg::OP_DELETE);
      cmd.load_rsp   = (state_ff == RESP) && rsp_free;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= skt_pkg::OP_COUNT;
         st_ff        <= skt_pkg::ST_DONE;
         pz_ff        <= 1'b1;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  op_ff <= req_op;
                  case (req_op) inside
                     skt_pkg::OP_INSERT, skt_pkg::OP_DELETE, skt_pkg::OP_SEARCH: begin
                        state_ff <= SCAN;
                     end
                     default: begin
                        st_ff    <= skt_pkg::ST_DONE;
                        pz_ff    <= 1'b1;
                        state_ff <= RESP;
                     end
                  endcase
               end
            end
            SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= DECIDE;
               end
            end
            DECIDE: begin
               case (op_ff)
                  skt_pkg::OP_INSERT: begin
                     pz_ff <= 1'b0;
                     if (stat.hit) begin
                        st_ff    <= skt_pkg::ST_DUPLICATE;
                        state_ff <= RESP;
                     end else if (stat.full) begin
                        st_ff    <= skt_pkg::ST_FULL;
                        state_ff <= RESP;
                     end else begin
                        st_ff    <= skt_pkg::ST_DONE;
                        state_ff <= SHIFT_UP;
                     end
                  end
                  skt_pkg::OP_DELETE: begin
                     if (stat.hit) begin
                        st_ff    <= skt_pkg::ST_DONE;
                        pz_ff    <= 1'b0;
                        state_ff <= SHIFT_DN;
                     end else begin
                        st_ff    <= skt_pkg::ST_NOT_FOUND;
                        pz_ff    <= 1'b1;
                        state_ff <= RESP;
                     end
                  end
                  default: begin
                     st_ff    <= stat.hit ? skt_pkg::ST_DONE : skt_pkg::ST_NOT_FOUND;
                     pz_ff    <= !stat.hit;
                     state_ff <= RESP;
                  end
               endcase
            end
            SHIFT_UP: begin
               if (stat.up_last) begin
                  state_ff <= DRAIN;
               end
            end
            SHIFT_DN: begin
               if (stat.dn_last) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               state_ff <= RESP;
            end
            RESP: begin
               if (rsp_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/sorted_key_table.sv
// count and clear go straight to the result; search walks the held keys, and insert
// and delete then shift the keys from the found slot on, up or down
// one item at a time: the next accept comes after the result is loaded, once the
// sequencer is back in idle; the walk and shift of the key memory set the pace
// a new item is taken while the previous result waits in the output register
// reset: synchronous, active high; empties the table, key memory is not cleared
module sorted_key_table #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  skt_pkg::skt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output skt_pkg::skt_rsp_type rsp_data
);

   skt_pkg::skt_cmd_type  cmd;
   skt_pkg::skt_stat_type stat;

   // sequencer
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // key memory, walk and shift
   skt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_key  (req_data.key),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
